@@ design/swm_pkg.sv @@
package swm_pkg;

    // Pattern store capacity in bytes.
    localparam int MAX_PATTERN = 64;

    // Number of automaton positions, one past the last pattern byte.
    localparam int NPOS = MAX_PATTERN + 1;

    // Width of the pattern length counter, which must hold MAX_PATTERN itself.
    localparam int LEN_W = $clog2(NPOS);

    // Levels of the parallel-prefix network that spreads activity across star runs.
    localparam int LEVELS = $clog2(NPOS);

    // The only metacharacter.
    localparam logic [7:0] STAR_BYTE = 8'h2A;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TOPIC  = 2'd2,
        OP_END    = 2'd3
    } swm_op_t;

    // Per-cell control for one accepted item.
    typedef struct packed {
        logic load;     // write the incoming byte into this cell's pattern slot
        logic consume;  // advance the active bit by one topic byte
        logic rearm;    // return the active bit to its start value
    } swm_cell_ctrl_t;

endpackage

@@ design/swm_cell.sv @@
module swm_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  swm_pkg::swm_cell_ctrl_t ctrl,
    input  logic                    first,
    input  logic                    in_pat,
    input  logic [7:0]              char_in,
    input  logic                    closed,
    input  logic                    fwd_in,
    output logic                    active,
    output logic                    star,
    output logic                    fwd_out
);
    import swm_pkg::*;

    logic [7:0] char_reg;
    logic       state_reg;
    logic       state_next;
    logic       is_star;
    logic       keep;
    logic       active_next;

    // The stored bit is the active bit relative to its start value, so that
    // reset to zero leaves the first position active.
    assign active  = state_reg ^ first;
    assign is_star = (char_reg == STAR_BYTE);
    assign star    = in_pat & is_star;
    assign keep    = in_pat & closed & is_star;
    assign fwd_out = in_pat & closed & (is_star | (char_reg == char_in));

    always_comb
    begin
        active_next = active;
        if (ctrl.rearm)
        begin
            active_next = first;
        end
        else if (ctrl.consume)
        begin
            active_next = keep | fwd_in;
        end
        state_next = active_next ^ first;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            char_reg <= char_in;
        end
    end

endmodule

@@ design/swm_closure.sv @@
module swm_closure (
    input  logic [swm_pkg::NPOS-1:0] act,
    input  logic [swm_pkg::NPOS-2:0] star,
    output logic [swm_pkg::NPOS-1:0] closed
);
    import swm_pkg::*;

    // Position i is reached from i-1 when i-1 is an active star. This is a
    // carry-style chain, resolved by a Kogge-Stone prefix in LEVELS steps.
    logic [NPOS-1:0] g_lvl [LEVELS+1];
    logic [NPOS-1:0] p_lvl [LEVELS+1];

    always_comb
    begin
        g_lvl[0] = act;
        p_lvl[0] = {star, 1'b0};
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int i = 0; i < NPOS; i++)
            begin
                if (i >= (1 << l))
                begin
                    g_lvl[l+1][i] = g_lvl[l][i] | (p_lvl[l][i] & g_lvl[l][i - (1 << l)]);
                    p_lvl[l+1][i] = p_lvl[l][i] & p_lvl[l][i - (1 << l)];
                end
                else
                begin
                    g_lvl[l+1][i] = g_lvl[l][i];
                    p_lvl[l+1][i] = 1'b0;
                end
            end
        end
        closed = g_lvl[LEVELS];
    end

endmodule

@@ design/star_wildcard_match_core.sv @@
// Streamed glob matcher with '*' as its only metacharacter. Each transfer
// carries an operation and a byte: clear empties the pattern, append adds one
// pattern byte, a topic byte advances the match, and end of topic returns one
// result transfer with the verdict and the sticky overflow flag, then rearms
// for the next topic. A '*' matches any run of bytes, including the empty run
// and '/'; every other byte matches only itself. The pattern holds up to
// MAX_PATTERN bytes; appending to a full pattern drops the byte and sets the
// overflow flag, after which every topic fails until the next clear. Any
// append restarts a topic in progress. One transfer per clock is sustained
// while the result side keeps up; the cycle is set by the row of position
// cells and the prefix network that carries activity across runs of stars.
// The end-of-topic result sits in an output register, and while it waits
// with out_ready low no input transfer of any kind is taken.
module star_wildcard_match_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] char_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       pattern_overflow
);
    import swm_pkg::*;

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              last_act_reg;
    logic              last_act_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              matched_reg;
    logic              overflow_reg;

    logic              in_fire;
    logic              is_clear;
    logic              is_append;
    logic              is_topic;
    logic              is_end;
    logic              full;
    logic              do_load;

    logic [NPOS-1:0]   act;
    logic [NPOS-1:0]   closed;
    logic [NPOS-2:0]   star;
    logic [NPOS-2:0]   fwd;

    // An end of topic may only be taken when the result register is free or
    // is being emptied in the same cycle. The same ready covers every other
    // operation as well, so all input is held off while a result waits.
    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_fire   = in_valid & in_ready;
    assign is_clear  = (operation == OP_CLEAR);
    assign is_append = (operation == OP_APPEND);
    assign is_topic  = (operation == OP_TOPIC);
    assign is_end    = (operation == OP_END);
    assign full      = (len_reg == LEN_W'(MAX_PATTERN));
    assign do_load   = in_fire & is_append & ~full;

    // One cell per pattern position. Each cell hands its forward bit to its
    // neighbor, which is how a matched byte moves the automaton one step on.
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        swm_cell_ctrl_t ctrl;
        logic           fwd_prev;

        assign ctrl.load    = do_load & (len_reg == LEN_W'(i));
        assign ctrl.consume = in_fire & is_topic;
        assign ctrl.rearm   = in_fire & ~is_topic;

        if (i == 0)
        begin : g_head
            assign fwd_prev = 1'b0;
        end
        else
        begin : g_body
            assign fwd_prev = fwd[i-1];
        end

        swm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .first   (i == 0),
            .in_pat  (len_reg > LEN_W'(i)),
            .char_in (char_byte),
            .closed  (closed[i]),
            .fwd_in  (fwd_prev),
            .active  (act[i]),
            .star    (star[i]),
            .fwd_out (fwd[i])
        );
    end

    // The position past the last pattern byte has no pattern byte of its own.
    assign act[NPOS-1] = last_act_reg;

    swm_closure u_closure (
        .act    (act),
        .star   (star),
        .closed (closed)
    );

    always_comb
    begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        last_act_next  = last_act_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        if (in_fire)
        begin
            if (is_clear)
            begin
                len_next = '0;
                ovf_next = 1'b0;
            end
            if (is_append)
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
            if (is_topic)
            begin
                last_act_next = fwd[NPOS-2];
            end
            else
            begin
                last_act_next = 1'b0;
            end
            if (is_end)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            last_act_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            last_act_reg  <= last_act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The verdict reads the closed active set at the position just past the
    // pattern; an overflowed pattern never matches.
    always_ff @(posedge clk)
    begin
        if (in_fire && is_end)
        begin
            matched_reg  <= closed[len_reg] & ~ovf_reg;
            overflow_reg <= ovf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = overflow_reg;

endmodule
